### hdl/indexed_array_insert_delete_unit_defines.svh
// ----------------------------------------------------------------------------
// Indexed array insert/delete unit assertion macros
// Shared helpers for the concurrent checks of the unit.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ARRAY_INSERT_DELETE_UNIT_DEFINES_SVH
`define INDEXED_ARRAY_INSERT_DELETE_UNIT_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define IAID_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define IAID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/iaid_pkg.sv
// ----------------------------------------------------------------------------
// Indexed array insert/delete package
// Field widths, status and operation codes, and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package iaid_pkg;

    localparam int C_CNT_W = 6;
    localparam int C_POS_W = 5;
    localparam int C_VAL_W = 32;
    localparam int C_MAX_W = 31;
    localparam int C_ST_W  = 2;

    localparam int C_IN_TDATA_W  = 40;
    localparam int C_OUT_TDATA_W = 72;

    localparam logic [C_CNT_W-1:0] C_CAP_RESET = 6'd32;

    localparam logic [C_ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [C_ST_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [C_ST_W-1:0] ST_FULL      = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef logic signed [C_VAL_W-1:0] t_value;
    typedef logic [C_MAX_W-1:0]        t_max;
    typedef logic [C_CNT_W-1:0]        t_count;
    typedef logic [C_POS_W-1:0]        t_pos;

    typedef struct packed {
        logic   en;
        logic   op;
        t_pos   pos;
        t_value value;
    } t_cmd;

endpackage

`default_nettype wire

### hdl/iaid_cell.sv
// ----------------------------------------------------------------------------
// Indexed array insert/delete cell
// Holds one list entry and shifts it to or from its neighbors on a request.
// ----------------------------------------------------------------------------
`default_nettype none

module iaid_cell
    import iaid_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int DEPTH = 32
) (
    input  wire logic   i_clk,
    input  wire t_cmd   i_cmd,
    input  wire t_count i_count,
    input  wire t_value i_left,
    input  wire t_value i_right,
    output t_value      o_value,
    output t_max        o_leaf
);

    localparam int IW = $clog2(DEPTH) + C_CNT_W + 1;

    t_value r_value;
    t_value n_value;
    logic   w_at_pos;
    logic   w_after;
    logic   w_live;

    assign w_at_pos = (IW'(i_cmd.pos) == IW'(INDEX));
    assign w_after  = (IW'(i_cmd.pos) < IW'(INDEX));
    assign w_live   = (IW'(INDEX) < IW'(i_count));

    always_comb begin
        n_value = r_value;
        if (i_cmd.en) begin
            if (i_cmd.op == OP_INSERT) begin
                if (w_at_pos) begin
                    n_value = i_cmd.value;
                end else if (w_after) begin
                    n_value = i_left;
                end
            end else if (w_at_pos || w_after) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_leaf  = (w_live && !r_value[C_VAL_W-1]) ? r_value[C_MAX_W-1:0] : '0;

endmodule

`default_nettype wire

### hdl/iaid_max_tree.sv
// ----------------------------------------------------------------------------
// Indexed array insert/delete maximum tree
// Registered pairwise maximum over all cell leaves, one tree level per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iaid_max_tree
    import iaid_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic i_clk,
    input  wire t_max i_leaf [DEPTH],
    output t_max      o_max
);

    localparam int LEVELS = $clog2(DEPTH);
    localparam int P      = 1 << LEVELS;

    t_max w_leaf [P];
    t_max r_heap [1:P-1];

    for (genvar k = 0; k < P; k++) begin : g_leaf
        if (k < DEPTH) begin : g_real
            assign w_leaf[k] = i_leaf[k];
        end else begin : g_pad
            assign w_leaf[k] = '0;
        end
    end

    for (genvar n = 1; n < P; n++) begin : g_node
        if (2 * n >= P) begin : g_bottom
            always_ff @(posedge i_clk) begin
                r_heap[n] <= (w_leaf[2*n-P] > w_leaf[2*n+1-P]) ?
                             w_leaf[2*n-P] : w_leaf[2*n+1-P];
            end
        end else begin : g_inner
            always_ff @(posedge i_clk) begin
                r_heap[n] <= (r_heap[2*n] > r_heap[2*n+1]) ? r_heap[2*n] : r_heap[2*n+1];
            end
        end
    end

    assign o_max = r_heap[1];

endmodule

`default_nettype wire

### hdl/indexed_array_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// Indexed array insert/delete unit
// Packed list of signed entries with insert and delete at a position,
// reporting status, the moved value, the length and the floored maximum.
//
//   Channel   Dir  Handshake                       Contents
//   s_axis    in   s_axis_tvalid / s_axis_tready   operation, position, value
//   m_axis    out  m_axis_tvalid / m_axis_tready   status, value, length, max
//   cfg       in   i_cfg_valid / o_cfg_ready       capacity
//
// A request shifts the cell row, then waits for the registered maximum tree to
// settle before its result is loaded and the unit returns to idle.
// Reset clears the length and sets the capacity to 32; entries are not reset.
// A stalled result waits in the output register; the next request is taken
// once the previous result has moved there.
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_array_insert_delete_unit_defines.svh"

module indexed_array_insert_delete_unit
    import iaid_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // [4:0] position, [36:5] value, [39:37] zero
    input  wire logic [C_IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  wire logic                     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // [31:0] result_value, [37:32] length, [68:38] maximum, [71:69] zero
    output logic [C_OUT_TDATA_W-1:0]      m_axis_tdata,
    // [1:0] status
    output logic [C_ST_W-1:0]             m_axis_tuser,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [C_CNT_W-1:0]       i_cfg_data
);

    localparam int LEVELS  = $clog2(DEPTH);
    localparam int WW      = $clog2(LEVELS + 1);
    localparam int CAP_MAX = (DEPTH < 63) ? DEPTH : 63;
    localparam int RD_N    = (DEPTH < 32) ? DEPTH : 32;
    localparam logic [C_CNT_W-1:0] CAP_LIM   = C_CNT_W'(CAP_MAX);
    localparam logic [WW-1:0]      WAIT_INIT = WW'(LEVELS);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_CALC = 1'b1;

    logic [0:0]    r_state;
    logic [WW-1:0] r_wait;
    t_count        r_count;
    t_count        n_count;
    t_count        r_cap;
    logic [C_ST_W-1:0] r_res_status;
    t_value        r_res_value;
    logic          r_out_valid;
    logic [C_ST_W-1:0] r_out_status;
    t_value        r_out_value;
    t_count        r_out_count;
    t_max          r_out_max;

    logic          w_s_fire;
    logic          w_op;
    t_pos          w_pos;
    t_value        w_val;
    t_count        w_pos_ext;
    t_count        w_eff_cap;
    logic [C_ST_W-1:0] w_status;
    t_value        w_rd_val;
    t_value        w_res;
    t_cmd          w_cmd;
    t_max          w_max;
    logic          w_load;
    t_value        w_cell_val [DEPTH];
    t_max          w_leaf [DEPTH];

    assign w_s_fire  = s_axis_tvalid & s_axis_tready;
    assign w_op      = s_axis_tuser;
    assign w_pos     = s_axis_tdata[C_POS_W-1:0];
    assign w_val     = signed'(s_axis_tdata[C_POS_W+C_VAL_W-1:C_POS_W]);
    assign w_pos_ext = {1'b0, w_pos};
    assign w_eff_cap = (r_cap < CAP_LIM) ? r_cap : CAP_LIM;

    always_comb begin
        if (w_op == OP_INSERT) begin
            priority if (w_pos_ext > r_count) begin
                w_status = ST_BAD_INDEX;
            end else if (r_count >= w_eff_cap) begin
                w_status = ST_FULL;
            end else begin
                w_status = ST_OK;
            end
        end else begin
            w_status = (w_pos_ext >= r_count) ? ST_BAD_INDEX : ST_OK;
        end
    end

    always_comb begin
        w_rd_val = '0;
        for (int k = 0; k < RD_N; k++) begin
            if (w_pos == C_POS_W'(k)) begin
                w_rd_val = w_cell_val[k];
            end
        end
    end

    always_comb begin
        w_res   = '0;
        n_count = r_count;
        if (w_status == ST_OK) begin
            if (w_op == OP_INSERT) begin
                w_res   = w_val;
                n_count = r_count + 1'b1;
            end else begin
                w_res   = w_rd_val;
                n_count = r_count - 1'b1;
            end
        end
    end

    assign w_cmd.en    = w_s_fire && (w_status == ST_OK);
    assign w_cmd.op    = w_op;
    assign w_cmd.pos   = w_pos;
    assign w_cmd.value = w_val;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_value w_left;
        t_value w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_val[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell_val[i+1];
        end
        iaid_cell #(
            .INDEX (i),
            .DEPTH (DEPTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_cell_val[i]),
            .o_leaf  (w_leaf[i])
        );
    end

    iaid_max_tree #(
        .DEPTH (DEPTH)
    ) u_max_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_max  (w_max)
    );

    assign w_load = (r_state == S_CALC) && (r_wait == '0) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= '0;
            r_count     <= '0;
            r_cap       <= C_CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (w_s_fire) begin
                r_count <= n_count;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_fire) begin
                        r_state <= S_CALC;
                        r_wait  <= WAIT_INIT;
                    end
                end
                S_CALC: begin
                    if (r_wait != '0) begin
                        r_wait <= r_wait - 1'b1;
                    end else if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_res_status <= w_status;
            r_res_value  <= w_res;
        end
        if (w_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_count  <= r_count;
            r_out_max    <= w_max;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {3'b000, r_out_max, r_out_count, r_out_value};

    `IAID_ASSERT_ALWAYS(a_count_limit, i_clk, i_rst_n, r_count <= CAP_LIM, "Length beyond limit.")
    `IAID_ASSERT_NEXT(a_accept_calc, i_clk, i_rst_n, w_s_fire, (r_state == S_CALC) && (r_wait == WAIT_INIT), "Request did not start the tree wait.")
    `IAID_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, w_s_fire && (w_status == ST_OK) && (w_op == OP_INSERT), r_count == $past(r_count) + 1'b1, "Insert did not grow the list.")
    `IAID_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !w_s_fire, $stable(r_count), "Length changed without a request.")

endmodule

`default_nettype wire

### verif/tb_indexed_array_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// Indexed array insert/delete unit testbench
// Sends insert and delete requests over the input stream and checks each
// result against a behavioral copy of the list kept in the testbench. The
// run walks through several capacity settings, including zero, values above
// the store depth and values below the current length. It also walks through
// phases with no idling, a mostly idle sender, a mostly stalling receiver,
// and light idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_indexed_array_insert_delete_unit
    import iaid_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = 32;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic   op;
        t_pos   pos;
        t_value value;
    } t_request;

    typedef struct packed {
        logic [C_ST_W-1:0] status;
        t_value            value;
        t_count            length;
        t_max              maximum;
    } t_outcome;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [C_IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                     s_axis_tuser = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [C_OUT_TDATA_W-1:0] m_axis_tdata;
    logic [C_ST_W-1:0]        m_axis_tuser;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [C_CNT_W-1:0]       i_cfg_data = '0;

    t_request request_q[$];
    t_outcome expected_outcomes[$];

    t_value list_vals [LIST_DEPTH];
    int     list_len = 0;
    int     cap_setting = C_CAP_RESET;

    int     plan_len = 0;
    int     plan_lim = LIST_DEPTH;
    logic   filling = 1'b1;

    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    logic   req_taken = 1'b0;
    int     errors = 0;
    int     cycle_count = 0;
    t_outcome seen_outcome;
    t_outcome want_outcome;

    indexed_array_insert_delete_unit #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int effective_limit(input int cap);
        return (cap < LIST_DEPTH) ? cap : LIST_DEPTH;
    endfunction

    function automatic t_outcome apply_request(input t_request r);
        t_outcome o;
        t_value   top;
        int       k;
        o.status = ST_OK;
        o.value = '0;
        if (r.op == OP_INSERT) begin
            if (int'(r.pos) > list_len) begin
                o.status = ST_BAD_INDEX;
            end else if (list_len >= effective_limit(cap_setting)) begin
                o.status = ST_FULL;
            end else begin
                for (k = list_len; k > int'(r.pos); k--) list_vals[k] = list_vals[k-1];
                list_vals[r.pos] = r.value;
                list_len++;
                o.value = r.value;
            end
        end else begin
            if (int'(r.pos) >= list_len) begin
                o.status = ST_BAD_INDEX;
            end else begin
                o.value = list_vals[r.pos];
                for (k = r.pos; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
                list_len--;
            end
        end
        top = '0;
        for (k = 0; k < list_len; k++) begin
            if (!list_vals[k][C_VAL_W-1] && list_vals[k] > top) top = list_vals[k];
        end
        o.length = t_count'(list_len);
        o.maximum = top[C_MAX_W-1:0];
        return o;
    endfunction

    function automatic void queue_request(input logic op, input int pos, input t_value val);
        t_request r;
        r.op = op;
        r.pos = t_pos'(pos);
        r.value = val;
        request_q.push_back(r);
        if (op == OP_INSERT) begin
            if (pos <= plan_len && plan_len < plan_lim) plan_len++;
        end else if (pos < plan_len) begin
            plan_len--;
        end
    endfunction

    function automatic t_value random_value();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            4: return t_value'($urandom_range(32)) - 32'sd16;
            default: return t_value'($urandom);
        endcase
    endfunction

    task automatic queue_random_requests(input int n);
        logic op;
        int   pos;
        repeat (n) begin
            if (plan_len >= plan_lim && $urandom_range(7) == 0) begin
                filling = 1'b0;
            end else if (plan_len == 0 && $urandom_range(7) == 0) begin
                filling = 1'b1;
            end
            if ($urandom_range(99) < 12) begin
                op = $urandom_range(1);
                pos = $urandom_range(31);
            end else begin
                op = ($urandom_range(99) < (filling ? 25 : 75)) ? OP_DELETE : OP_INSERT;
                if (op == OP_INSERT) begin
                    pos = $urandom_range((plan_len < 31) ? plan_len : 31);
                end else begin
                    pos = (plan_len == 0) ? 0 : $urandom_range(plan_len - 1);
                end
            end
            queue_request(op, pos, random_value());
        end
    endtask

    task automatic reconfigure(input int cap, input int idle_pct, input int stall_pct);
        while (request_q.size() != 0 || expected_outcomes.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= t_count'(cap);
        do @(posedge i_clk); while (!o_cfg_ready);
        cap_setting = cap;
        plan_lim = effective_limit(cap);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !req_taken)) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {3'b000, request_q[0].value, request_q[0].pos};
                s_axis_tuser <= request_q[0].op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_outcomes.push_back(apply_request(request_q.pop_front()));
            req_taken = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_outcome.status = m_axis_tuser;
            seen_outcome.value = m_axis_tdata[31:0];
            seen_outcome.length = m_axis_tdata[37:32];
            seen_outcome.maximum = m_axis_tdata[68:38];
            if (expected_outcomes.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding: status %0d value %0d",
                         $realtime, seen_outcome.status, seen_outcome.value);
            end else begin
                want_outcome = expected_outcomes.pop_front();
                if (seen_outcome !== want_outcome) begin
                    errors++;
                    $display("%0t: expected status %0d value %0d length %0d maximum %0d",
                             $realtime, want_outcome.status, want_outcome.value,
                             want_outcome.length, want_outcome.maximum);
                    $display("%0t: actual   status %0d value %0d length %0d maximum %0d",
                             $realtime, seen_outcome.status, seen_outcome.value,
                             seen_outcome.length, seen_outcome.maximum);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_request(OP_DELETE, 0, '0);
        queue_request(OP_INSERT, 1, 32'sd7);
        queue_request(OP_INSERT, 31, 32'sd7);
        queue_request(OP_INSERT, 0, 32'sh8000_0000);
        queue_request(OP_INSERT, 1, 32'sh7fff_ffff);
        queue_request(OP_INSERT, 0, '0);
        queue_request(OP_INSERT, 3, -32'sd1);
        queue_request(OP_INSERT, 2, 32'sd5);
        queue_request(OP_DELETE, 5, 32'sh7fff_ffff);
        queue_request(OP_DELETE, 4, '0);
        queue_request(OP_DELETE, 0, '0);
        queue_request(OP_DELETE, 1, '0);
        queue_request(OP_INSERT, 0, 32'sh5555_5555);
        queue_request(OP_INSERT, 1, 32'shaaaa_aaaa);
        queue_request(OP_DELETE, 31, '0);
        queue_random_requests(250);

        reconfigure(63, 88, 0);
        queue_random_requests(300);
        repeat (6) queue_request(OP_INSERT, 0, random_value());

        reconfigure(3, 0, 88);
        queue_random_requests(250);

        reconfigure(0, 16, 16);
        queue_request(OP_INSERT, 0, 32'sd1);
        queue_request(OP_INSERT, 31, 32'sd1);
        queue_request(OP_DELETE, 0, '0);
        queue_random_requests(120);

        reconfigure(1, 0, 0);
        queue_random_requests(200);

        reconfigure(32, 88, 0);
        queue_random_requests(250);

        reconfigure(17, 0, 88);
        queue_random_requests(200);

        reconfigure(63, 16, 16);
        queue_random_requests(250);

        while (request_q.size() != 0 || expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
